/* hdl/rrfo_pkg.sv */
`default_nettype none
package rrfo_pkg;

    // request codes carried in s_tuser
    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // shape bytes
    localparam logic [7:0] SHAPE_OUTLINE = 8'd114;
    localparam logic [7:0] SHAPE_FILLED  = 8'd82;

    // configuration register indexes
    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int SIDE_REG_W = 10;
    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 20;
    localparam int RDPOS_W    = 9;
    localparam logic [CHAR_W-1:0] BG_RESET = 8'd32;

    // input tdata layout, lowest bit first
    localparam int SHAPE_LSB = 0;
    localparam int LEFT_LSB  = SHAPE_LSB + 8;
    localparam int TOP_LSB   = LEFT_LSB + COORD_W;
    localparam int RW_LSB    = TOP_LSB + COORD_W;
    localparam int RH_LSB    = RW_LSB + COORD_W;
    localparam int PAINT_LSB = RH_LSB + COORD_W;
    localparam int RCOL_LSB  = PAINT_LSB + CHAR_W;
    localparam int RROW_LSB  = RCOL_LSB + RDPOS_W;
    localparam int S_USED_W  = RROW_LSB + RDPOS_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

endpackage
`default_nettype wire

/* hdl/rectangle_raster_fill_outline.sv */
`default_nettype none
// Rectangle rasterizer over a byte framebuffer of MAX_SIDE x MAX_SIDE pixels held in one
// single-port memory, addressed row*MAX_SIDE+col. Each request yields exactly one result
// transaction. A clear request writes background_char to the whole memory, one pixel a
// cycle. A draw request that passes its checks scans the area in use, canvas_width x
// canvas_height, one pixel a cycle through a shared compare unit; a rejected draw or an
// unused request code goes straight to the result, and a read passes through the
// registered memory read first. The input side is ready only between requests; a
// finished result sits in the output register and the next request is taken while it
// waits. The memory holds nothing defined until the first clear; there is no sweep after
// reset. Configuration writes are taken at any time but must only be issued while no
// request is in flight.
module rectangle_raster_fill_outline
    import rrfo_pkg::*;
#(
    parameter int MAX_SIDE  = 512,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // shape_code, left_x, top_y, rect_width, rect_height, paint_char, read_col,
    // read_row, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_char
    output logic [M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [M_TUSER_W-1:0]       m_tuser
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SV_W   = $clog2(MAX_SIDE + 1);
    // coordinate compare width: covers pixel positions and the 20-bit sums
    localparam int CW     = (SIDE_W + FRAC_BITS + 2 > COORD_W + 3) ?
                            (SIDE_W + FRAC_BITS + 2) : (COORD_W + 3);
    localparam int RA_W   = ADDR_W + RDPOS_W + 2;

    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_READ,
        S_RESP
    } state_t;

    // configuration registers
    logic [SIDE_REG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [CHAR_W-1:0]     bg_reg;

    // sequencer and datapath registers
    state_t                 state_reg;
    logic [SIDE_W-1:0]      col_reg, row_reg;
    logic [ADDR_W-1:0]      addr_reg, row_base_reg;
    logic signed [CW-1:0]   l_reg, r_reg, t_reg, b_reg;
    logic signed [CW-1:0]   l1_reg, r1_reg, t1_reg, b1_reg;
    logic                   filled_reg;
    logic [CHAR_W-1:0]      paint_reg;
    logic                   rd_hit_reg;
    logic                   status_reg;
    logic [CHAR_W-1:0]      rd_data_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    // canvas memory
    logic [CHAR_W-1:0] canvas_mem [DEPTH];
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;

    // request fields
    logic [1:0]                req_type;
    logic [7:0]                shape_code;
    logic signed [COORD_W-1:0] left_x, top_y, rect_width, rect_height;
    logic [CHAR_W-1:0]         paint_char;
    logic [RDPOS_W-1:0]        read_col, read_row;

    assign req_type    = s_tuser[1:0];
    assign shape_code  = s_tdata[SHAPE_LSB +: 8];
    assign left_x      = s_tdata[LEFT_LSB +: COORD_W];
    assign top_y       = s_tdata[TOP_LSB +: COORD_W];
    assign rect_width  = s_tdata[RW_LSB +: COORD_W];
    assign rect_height = s_tdata[RH_LSB +: COORD_W];
    assign paint_char  = s_tdata[PAINT_LSB +: CHAR_W];
    assign read_col    = s_tdata[RCOL_LSB +: RDPOS_W];
    assign read_row    = s_tdata[RROW_LSB +: RDPOS_W];

    // size registers clamped to 1..MAX_SIDE
    function automatic logic [SV_W-1:0] side_use(input logic [SIDE_REG_W-1:0] v);
        if (v == '0)
            return SV_W'(1);
        else if (11'(v) > 11'(MAX_SIDE))
            return SV_W'(MAX_SIDE);
        else
            return SV_W'(v);
    endfunction

    logic [SV_W-1:0] cw_use, ch_use;
    assign cw_use = side_use(width_cfg_reg);
    assign ch_use = side_use(height_cfg_reg);

    // request decode at accept time
    logic                 s_fire;
    logic                 shape_ok, size_ok, draw_ok;
    logic signed [CW-1:0] l_ext, t_ext, r_ext, b_ext;
    logic [RA_W-1:0]      rd_addr_full;
    logic                 rd_in_range;

    assign s_fire   = s_tvalid && s_tready;
    assign shape_ok = (shape_code == SHAPE_OUTLINE) || (shape_code == SHAPE_FILLED);
    assign size_ok  = !rect_width[COORD_W-1] && (rect_width != '0) &&
                      !rect_height[COORD_W-1] && (rect_height != '0);
    assign draw_ok  = shape_ok && size_ok;
    assign l_ext    = CW'(left_x);
    assign t_ext    = CW'(top_y);
    assign r_ext    = l_ext + CW'(rect_width);
    assign b_ext    = t_ext + CW'(rect_height);
    assign rd_addr_full = RA_W'(read_row) * RA_W'(MAX_SIDE) + RA_W'(read_col);
    assign rd_in_range  = (11'(read_col) < 11'(cw_use)) && (11'(read_row) < 11'(ch_use));

    // shared per-pixel classifier: pixel sits at (col, row) in fixed point
    logic signed [CW-1:0] px, py;
    logic                 in_rect, near_edge, paint_hit;
    logic                 col_last, row_last;

    assign px        = $signed(CW'(col_reg) << FRAC_BITS);
    assign py        = $signed(CW'(row_reg) << FRAC_BITS);
    assign in_rect   = (px >= l_reg) && (px <= r_reg) && (py >= t_reg) && (py <= b_reg);
    assign near_edge = (px < l1_reg) || (px > r1_reg) || (py < t1_reg) || (py > b1_reg);
    assign paint_hit = in_rect && (filled_reg || near_edge);
    assign col_last  = SV_W'(col_reg) == (cw_use - SV_W'(1));
    assign row_last  = SV_W'(row_reg) == (ch_use - SV_W'(1));

    // memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = paint_reg;
        unique case (state_reg)
            S_DRAW: begin
                mem_we    = paint_hit;
                mem_wdata = paint_reg;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = bg_reg;
            end
            default: begin
                mem_we    = 1'b0;
                mem_wdata = paint_reg;
            end
        endcase
    end

    // single port canvas, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            canvas_mem[addr_reg] <= mem_wdata;
        end
        rd_data_reg <= canvas_mem[addr_reg];
    end

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= SIDE_REG_W'(1);
            height_cfg_reg <= SIDE_REG_W'(1);
            bg_reg         <= BG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  width_cfg_reg  <= cfg_data[SIDE_REG_W-1:0];
                CFG_CANVAS_HEIGHT: height_cfg_reg <= cfg_data[SIDE_REG_W-1:0];
                CFG_BACKGROUND:    bg_reg         <= cfg_data[CHAR_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output register drains independently of the sequencer;
            // in S_RESP the load below decides valid
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        unique case (req_type)
                            REQ_DRAW: begin
                                // corner and edge bounds latched once per draw
                                l_reg        <= l_ext;
                                t_reg        <= t_ext;
                                r_reg        <= r_ext;
                                b_reg        <= b_ext;
                                l1_reg       <= l_ext + ONE;
                                t1_reg       <= t_ext + ONE;
                                r1_reg       <= r_ext - ONE;
                                b1_reg       <= b_ext - ONE;
                                filled_reg   <= (shape_code == SHAPE_FILLED);
                                paint_reg    <= paint_char;
                                col_reg      <= '0;
                                row_reg      <= '0;
                                addr_reg     <= '0;
                                row_base_reg <= '0;
                                rd_hit_reg   <= 1'b0;
                                status_reg   <= !draw_ok;
                                state_reg    <= draw_ok ? S_DRAW : S_RESP;
                            end
                            REQ_READ: begin
                                addr_reg   <= rd_addr_full[ADDR_W-1:0];
                                rd_hit_reg <= rd_in_range;
                                status_reg <= 1'b0;
                                state_reg  <= S_READ;
                            end
                            REQ_CLEAR: begin
                                addr_reg   <= '0;
                                rd_hit_reg <= 1'b0;
                                status_reg <= 1'b0;
                                state_reg  <= S_CLEAR;
                            end
                            default: begin
                                // unused request code: zero result
                                rd_hit_reg <= 1'b0;
                                status_reg <= 1'b0;
                                state_reg  <= S_RESP;
                            end
                        endcase
                    end
                end

                S_CLEAR: begin
                    if (addr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= S_RESP;
                    end else begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end

                S_DRAW: begin
                    // raster scan, one pixel per cycle
                    if (col_last) begin
                        if (row_last) begin
                            state_reg <= S_RESP;
                        end else begin
                            col_reg      <= '0;
                            row_reg      <= row_reg + SIDE_W'(1);
                            row_base_reg <= row_base_reg + ADDR_W'(MAX_SIDE);
                            addr_reg     <= row_base_reg + ADDR_W'(MAX_SIDE);
                        end
                    end else begin
                        col_reg  <= col_reg + SIDE_W'(1);
                        addr_reg <= addr_reg + ADDR_W'(1);
                    end
                end

                S_READ: begin
                    // memory read issued this cycle, data valid in S_RESP
                    state_reg <= S_RESP;
                end

                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= rd_hit_reg ? rd_data_reg : '0;
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

/* hdl/rrfo_checker.sv */
`default_nettype none
module rrfo_checker
    import rrfo_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic [S_TUSER_W-1:0]  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // a rejected draw carries no pixel byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("rejected draw with nonzero pixel");

    // one request in flight: ready drops after every request transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

    // a new result only comes from a request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without request");

endmodule

bind rectangle_raster_fill_outline rrfo_checker u_rrfo_checker (.*);
`default_nettype wire
